[sv/rbbs_pkg.sv]
package rbbs_pkg;

  // Default ring depth in bytes
  localparam int unsigned BufDepthDefault = 4096;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned BitPosW = 3;

  // Request codes
  localparam logic [1:0] ReqTick   = 2'd0;
  localparam logic [1:0] ReqWrite  = 2'd1;
  localparam logic [1:0] ReqCancel = 2'd2;

  // Write status codes
  localparam logic [1:0] WsNone   = 2'd0;
  localparam logic [1:0] WsOk     = 2'd1;
  localparam logic [1:0] WsFull   = 2'd2;
  localparam logic [1:0] WsNoRate = 2'd3;

  // Bit position after reset, so the first bit driven is bit 0
  localparam logic [BitPosW-1:0] BitPosReset = 3'd7;
  localparam logic [BitPosW-1:0] BitPosLast  = 3'd7;

  // Input beat
  typedef struct packed {
    logic [1:0]       req_type;
    logic [ByteW-1:0] data_byte;
  } in_t;

  // Result beat
  typedef struct packed {
    logic       pin_level;
    logic       bit_sent;
    logic [1:0] write_status;
    logic       space_ready;
    logic       busy_res;
  } out_t;

  // Control outcome of one item, handed from the control stage to the pin stage
  typedef struct packed {
    logic               bit_sent;
    logic [BitPosW-1:0] bit_pos;
    logic [1:0]         write_status;
    logic               space_ready;
    logic               busy_res;
  } stage_t;

endpackage

[sv/rbbs_ram.sv]
module rbbs_ram #(
  parameter int unsigned BufDepth = rbbs_pkg::BufDepthDefault,
  localparam int unsigned AddrW = $clog2(BufDepth)
) (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [AddrW-1:0]           waddr_i,
  input  logic [rbbs_pkg::ByteW-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [AddrW-1:0]           raddr_i,
  output logic [rbbs_pkg::ByteW-1:0] rdata_o
);
  import rbbs_pkg::*;

  logic [ByteW-1:0] mem [BufDepth];
  logic [ByteW-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds its data between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[sv/rbbs_ctrl.sv]
module rbbs_ctrl #(
  parameter int unsigned BufDepth = rbbs_pkg::BufDepthDefault,
  localparam int unsigned AddrW = $clog2(BufDepth)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         item_valid_i,
  input  rbbs_pkg::in_t                item_i,
  input  logic                         cfg_we_i,
  input  logic [rbbs_pkg::PeriodW-1:0] cfg_data_i,
  output rbbs_pkg::stage_t             stage_o,
  output logic                         mem_we_o,
  output logic [AddrW-1:0]             mem_waddr_o,
  output logic [rbbs_pkg::ByteW-1:0]   mem_wdata_o,
  output logic                         mem_re_o,
  output logic [AddrW-1:0]             mem_raddr_o
);
  import rbbs_pkg::*;

  localparam logic [AddrW-1:0] LastAddr = AddrW'(BufDepth - 1);
  localparam logic [AddrW:0]   DepthW   = (AddrW + 1)'(BufDepth);
  localparam logic [AddrW:0]   QuarterW = (AddrW + 1)'(BufDepth / 4);

  logic [PeriodW-1:0] period_q;
  logic [PeriodW-1:0] tick_q, tick_d;
  logic [AddrW-1:0]   rp_q, rp_d, wp_q, wp_d;
  logic               full_q, full_d;
  logic               run_q, run_d;
  logic               stop_q, stop_d;
  logic [BitPosW-1:0] bitpos_q, bitpos_d;

  logic [AddrW-1:0]   rp_wrap, wp_wrap;
  logic [AddrW:0]     used_after;
  logic               tick_hit;
  logic [BitPosW-1:0] bitpos_inc;

  // Pointer arithmetic
  assign rp_wrap    = (rp_q == LastAddr) ? '0 : rp_q + 1'b1;
  assign wp_wrap    = (wp_q == LastAddr) ? '0 : wp_q + 1'b1;
  assign used_after = (wp_q >= rp_wrap) ? ({1'b0, wp_q} - {1'b0, rp_wrap})
                                        : ({1'b0, wp_q} + DepthW - {1'b0, rp_wrap});
  assign tick_hit   = ({1'b0, tick_q} + 33'd1) >= {1'b0, period_q};
  assign bitpos_inc = bitpos_q + 1'b1;

  // Next state for one accepted item
  always_comb begin
    tick_d      = tick_q;
    rp_d        = rp_q;
    wp_d        = wp_q;
    full_d      = full_q;
    run_d       = run_q;
    stop_d      = stop_q;
    bitpos_d    = bitpos_q;
    stage_o     = '0;
    stage_o.bit_pos = bitpos_q;
    mem_we_o    = 1'b0;
    mem_waddr_o = wp_q;
    mem_wdata_o = item_i.data_byte;
    mem_re_o    = 1'b0;
    mem_raddr_o = rp_q;
    if (item_valid_i) begin
      unique case (item_i.req_type)
        ReqTick: begin
          if (run_q) begin
            if (tick_hit) begin
              tick_d = '0;
              if (stop_q) begin
                run_d  = 1'b0;
                stop_d = 1'b0;
              end else begin
                // Bit time: fetch the current byte, drive the next bit
                bitpos_d         = bitpos_inc;
                stage_o.bit_sent = 1'b1;
                stage_o.bit_pos  = bitpos_inc;
                mem_re_o         = 1'b1;
                if (bitpos_inc == BitPosLast) begin
                  rp_d = rp_wrap;
                  if (full_q && (used_after < QuarterW)) begin
                    full_d = 1'b0;
                  end else if (rp_wrap == wp_q) begin
                    run_d = 1'b0;
                  end
                end
              end
            end else begin
              tick_d = tick_q + 1'b1;
            end
          end
        end
        ReqWrite: begin
          if (period_q == '0) begin
            stage_o.write_status = WsNoRate;
          end else if (full_q) begin
            stage_o.write_status = WsFull;
          end else begin
            mem_we_o = 1'b1;
            wp_d     = wp_wrap;
            if (wp_wrap == rp_q) begin
              full_d = 1'b1;
            end
            if (!run_q) begin
              run_d  = 1'b1;
              tick_d = '0;
            end
            stage_o.write_status = WsOk;
          end
        end
        ReqCancel: begin
          if (run_q) begin
            stop_d = 1'b1;
          end
        end
        default: ;
      endcase
    end
    stage_o.space_ready = !full_d;
    stage_o.busy_res    = run_d;
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q   <= '0;
      rp_q     <= '0;
      wp_q     <= '0;
      full_q   <= 1'b0;
      run_q    <= 1'b0;
      stop_q   <= 1'b0;
      bitpos_q <= BitPosReset;
    end else begin
      tick_q   <= tick_d;
      rp_q     <= rp_d;
      wp_q     <= wp_d;
      full_q   <= full_d;
      run_q    <= run_d;
      stop_q   <= stop_d;
      bitpos_q <= bitpos_d;
    end
  end

  // Bit period register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= '0;
    end else if (cfg_we_i) begin
      period_q <= cfg_data_i;
    end
  end

  // A pending stop only exists while output runs
  assert property (@(posedge clk_i) disable iff (!rst_ni) stop_q |-> run_q)
    else $error("stop request without running output");

  // The single memory sees at most one access per item
  assert property (@(posedge clk_i) disable iff (!rst_ni) !(mem_we_o && mem_re_o))
    else $error("memory read and write in the same cycle");

  // No byte is stored while the rate is unset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (period_q == '0) |-> !mem_we_o)
    else $error("byte stored with zero bit period");

  // Bit position moves only when a bit is driven
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stage_o.bit_sent |=> (bitpos_q == $past(bitpos_q)))
    else $error("bit position moved without a bit");

endmodule

[sv/ring_buffered_bit_serializer_top.sv]
// Ring-buffered bit serialiser.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one request beat:
// a clock tick, a byte write into the ring, or a cancel. Every request beat
// yields exactly one result beat on the output channel (out_valid_o /
// out_stall_i / out_data_o) with the pin level, whether a bit was driven,
// the write status, the space flag and the busy flag.
// The bit period is set through cfg_valid_i / cfg_ready_o / cfg_data_i,
// always ready; write it only while no request is in flight.
// An accepted request passes the middle stage, then the output register.
// Throughput: one request per cycle unless the output stalls; each request
// makes at most one ring memory access (a write, or a read at a bit time)
// and the read data comes back in the following cycle to pick the pin level.
// Reset clears pointers, flags and counters, puts the pin low and the
// bit period to zero; the ring contents are not cleared.
// A stalled output holds its beat; a request keeps being accepted as long
// as the middle stage can move on, so the input stalls only when the
// output register and the middle stage are both occupied.
module ring_buffered_bit_serializer_top #(
  parameter int unsigned BufDepth = rbbs_pkg::BufDepthDefault
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  rbbs_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output rbbs_pkg::out_t               out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [rbbs_pkg::PeriodW-1:0] cfg_data_i
);
  import rbbs_pkg::*;

  localparam int unsigned AddrW = $clog2(BufDepth);

  logic               in_acc, out_free, s1_move;
  stage_t             stage, s1_q;
  logic               s1_valid_q;
  logic               out_valid_q;
  out_t               out_q;
  logic               pin_q, pin_now;
  logic               mem_we, mem_re;
  logic [AddrW-1:0]   mem_waddr, mem_raddr;
  logic [ByteW-1:0]   mem_wdata, mem_rdata;

  // Handshakes
  assign out_free    = !out_valid_q || !out_stall_i;
  assign s1_move     = s1_valid_q && out_free;
  assign in_stall_o  = s1_valid_q && !out_free;
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  rbbs_ctrl #(
    .BufDepth(BufDepth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_valid_i(in_acc),
    .item_i      (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .stage_o     (stage),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr)
  );

  rbbs_ram #(
    .BufDepth(BufDepth)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  // Middle stage: waits for the read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= stage;
    end
  end

  // Pin level: new bit from the fetched byte, else the held level
  assign pin_now = s1_q.bit_sent ? mem_rdata[s1_q.bit_pos] : pin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pin_q <= 1'b0;
    end else if (s1_move) begin
      pin_q <= pin_now;
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q.pin_level    <= pin_now;
      out_q.bit_sent     <= s1_q.bit_sent;
      out_q.write_status <= s1_q.write_status;
      out_q.space_ready  <= s1_q.space_ready;
      out_q.busy_res     <= s1_q.busy_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[bench/tb_ring_buffered_bit_serializer_top.sv]
`timescale 1ns / 100ps

module tb_ring_buffered_bit_serializer_top;
  import rbbs_pkg::*;

  localparam int unsigned Depth      = BufDepthDefault;
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int unsigned Phases     = 8;
  localparam int unsigned PhaseItems = 190;

  // request code the block has no meaning for
  localparam logic [1:0] ReqUnused = 2'd3;

  typedef enum logic [1:0] {StallNone, StallLight, StallHeavy} stall_mode_e;

  // Tracks ring, pointers and bit timing; one expected beat per request
  class serializer_scoreboard;
    logic [ByteW-1:0]   ring [Depth];
    int unsigned        rd_ptr;
    int unsigned        wr_ptr;
    bit                 full;
    bit                 running;
    bit                 stop_req;
    logic [BitPosW-1:0] bit_pos;
    logic [PeriodW-1:0] ticks;
    logic [PeriodW-1:0] period;
    logic               pin;
    out_t               expected_beats [$];
    int unsigned        errors;

    function new();
      rd_ptr   = 0;
      wr_ptr   = 0;
      full     = 1'b0;
      running  = 1'b0;
      stop_req = 1'b0;
      bit_pos  = BitPosReset;
      ticks    = '0;
      period   = '0;
      pin      = 1'b0;
      errors   = 0;
    endfunction

    function int unsigned wrap_next(int unsigned p);
      return (p + 1 >= Depth) ? 0 : p + 1;
    endfunction

    // one bit time; returns whether a bit went out on the pin
    function bit shift_bit();
      int unsigned used;
      if (stop_req) begin
        running  = 1'b0;
        stop_req = 1'b0;
        return 1'b0;
      end
      bit_pos = bit_pos + 1'b1;
      pin     = ring[rd_ptr][bit_pos];
      if (bit_pos == BitPosLast) begin
        rd_ptr = wrap_next(rd_ptr);
        used   = (wr_ptr + Depth - rd_ptr) % Depth;
        if (full && used < Depth / 4) begin
          full = 1'b0;
        end else if (rd_ptr == wr_ptr) begin
          running = 1'b0;
        end
      end
      return 1'b1;
    endfunction

    function void note_request(in_t req);
      out_t       beat;
      logic       sent;
      logic [1:0] status;
      sent   = 1'b0;
      status = WsNone;
      case (req.req_type)
        ReqTick: begin
          if (running) begin
            if ({1'b0, ticks} + 33'd1 >= {1'b0, period}) begin
              ticks = '0;
              sent  = shift_bit();
            end else begin
              ticks = ticks + 1'b1;
            end
          end
        end
        ReqWrite: begin
          if (period == '0) begin
            status = WsNoRate;
          end else if (full) begin
            status = WsFull;
          end else begin
            ring[wr_ptr] = req.data_byte;
            wr_ptr = wrap_next(wr_ptr);
            if (wr_ptr == rd_ptr) full = 1'b1;
            if (!running) begin
              running = 1'b1;
              ticks   = '0;
            end
            status = WsOk;
          end
        end
        ReqCancel: begin
          if (running) stop_req = 1'b1;
        end
        default: ;
      endcase
      beat.pin_level    = pin;
      beat.bit_sent     = sent;
      beat.write_status = status;
      beat.space_ready  = !full;
      beat.busy_res     = running;
      expected_beats.push_back(beat);
    endfunction

    function void check_field(string name, logic [1:0] want, logic [1:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_beats.size() == 0) begin
        $error("result beat with nothing expected: %p", got);
        errors++;
        return;
      end
      want = expected_beats.pop_front();
      check_field("pin_level", 2'(want.pin_level), 2'(got.pin_level));
      check_field("bit_sent", 2'(want.bit_sent), 2'(got.bit_sent));
      check_field("write_status", want.write_status, got.write_status);
      check_field("space_ready", 2'(want.space_ready), 2'(got.space_ready));
      check_field("busy_res", 2'(want.busy_res), 2'(got.busy_res));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [PeriodW-1:0] cfg_data = '0;

  serializer_scoreboard sb = new();

  int unsigned burst_left = 0;
  int unsigned cycle_count = 0;
  stall_mode_e stall_mode = StallNone;
  int unsigned mode_left = 0;

  ring_buffered_bit_serializer_top #(
    .BufDepth(Depth)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_data_i (cfg_data)
  );

  always #4 clk = ~clk;

  // Run limit
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver stall pattern: modes held for random stretches
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 2));
      mode_left  = $urandom_range(20, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      StallNone:  out_stall <= 1'b0;
      StallLight: out_stall <= ($urandom_range(0, 3) == 0);
      default:    out_stall <= ($urandom_range(0, 3) != 0);
    endcase
  end

  // Result beats
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // Send one request beat, opening a new burst after a random gap when due
  task automatic push(logic [1:0] kind, logic [ByteW-1:0] data);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    burst_left--;
    @(negedge clk);
    in_valid           = 1'b1;
    in_data.req_type   = kind;
    in_data.data_byte  = data;
    do @(posedge clk); while (in_stall);
    sb.note_request(in_data);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic settle();
    @(negedge clk);
    in_valid   = 1'b0;
    burst_left = 0;
    while (sb.expected_beats.size() != 0) @(posedge clk);
  endtask

  task automatic write_period(logic [PeriodW-1:0] value);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    sb.period = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic push_random(int unsigned write_pct);
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < write_pct) push(ReqWrite, 8'($urandom()));
    else if (roll < write_pct + 4) push(ReqCancel, 8'($urandom()));
    else if (roll < write_pct + 6) push(ReqUnused, 8'($urandom()));
    else push(ReqTick, 8'($urandom()));
  endtask

  initial begin
    int unsigned write_pct;
    logic [PeriodW-1:0] phase_period;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // rate unset: tick, refused write, idle cancel, unused code
    push(ReqTick, 8'h00);
    push(ReqWrite, 8'h00);
    push(ReqCancel, 8'h00);
    push(ReqUnused, 8'hFF);

    // one tick per bit, cancel mid-byte then resume on a fresh write
    settle();
    write_period(32'd1);
    push(ReqWrite, 8'hA5);
    push(ReqWrite, 8'h00);
    repeat (3) push(ReqTick, 8'h00);
    push(ReqCancel, 8'h00);
    repeat (2) push(ReqTick, 8'h00);
    push(ReqWrite, 8'hFF);
    repeat (4) push(ReqTick, 8'h00);

    // period cleared while shifting: a bit on every tick, writes refused
    settle();
    write_period('0);
    repeat (3) push(ReqTick, 8'h00);
    push(ReqWrite, 8'h80);

    // largest period: no bit time in reach, cancel stays pending
    settle();
    write_period('1);
    push(ReqWrite, 8'h7F);
    repeat (2) push(ReqTick, 8'h00);
    push(ReqCancel, 8'h00);

    // random phases over a spread of periods and write densities
    for (int unsigned p = 0; p < Phases; p++) begin
      case (p)
        0:       phase_period = 32'd1;
        1:       phase_period = 32'd2;
        2:       phase_period = '1;
        3:       phase_period = '0;
        4:       phase_period = 32'd3;
        default: phase_period = 32'($urandom_range(1, 6));
      endcase
      case ($urandom_range(0, 2))
        0:       write_pct = 4;
        1:       write_pct = 12;
        default: write_pct = 30;
      endcase
      settle();
      write_period(phase_period);
      repeat (PhaseItems) push_random(write_pct);
    end

    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
